>>> sv/fde_pkg.sv
// Package for the framebuffer draw engine: command codes, FNV constants, glyph font.
// No dependencies.
package fde_pkg;
  localparam int unsigned ScreenWidthDef  = 128;
  localparam int unsigned ScreenHeightDef = 64;
  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_POINT  = 3'd1,
    ACT_RECT   = 3'd2,
    ACT_GLYPH  = 3'd3,
    ACT_CHKSUM = 3'd4
  } action_e;

  // Glyph row lookup; unknown codes draw as a blank.
  function automatic logic [7:0] glyph_row(input logic [7:0] code, input logic [2:0] row);
    logic [63:0] g;
    g = 64'h0;
    unique case (code)
      8'h41:   g = 64'h1824_4242_7E42_4200;
      8'h48:   g = 64'h4242_427E_4242_4200;
      8'h49:   g = 64'h3E08_0808_0808_3E00;
      8'h4F:   g = 64'h3C42_4242_4242_3C00;
      8'h58:   g = 64'h4224_1818_1824_4200;
      default: g = 64'h0;
    endcase
    glyph_row = g[8*(7-row) +: 8];
  endfunction
endpackage

>>> sv/fde_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module fde_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

>>> sv/framebuffer_draw_engine.sv
// Framebuffer draw engine: sequencer walking a frame store held in fde_ram.
// Depends on fde_pkg and fde_ram.
// Reset: a clearing pass writes zero to all W*H pixels (W*H cycles) before
// the first command is taken. Cycles from accept to result word: clear W*H,
// checksum 2*W*H+2 (read and multiply alternate), rectangle (clipped area),
// glyph 64, point 1; an empty rectangle or unknown action answers at once.
// The result word is registered; the next command is taken once it is taken.
module framebuffer_draw_engine #(
  parameter int unsigned ScreenWidth  = fde_pkg::ScreenWidthDef,
  parameter int unsigned ScreenHeight = fde_pkg::ScreenHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: action[2:0], x_pos[13:3], y_pos[24:14], rect_width[35:25],
  // rect_height[46:36], char_code[54:47], pixel_color[62:55], zero[63]
  input  logic [63:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: result_value[31:0]
  output logic [31:0] m_axis_tdata_o
);
  import fde_pkg::*;

  localparam int unsigned Depth = ScreenWidth * ScreenHeight;
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned XW = $clog2(ScreenWidth);
  localparam int unsigned YW = $clog2(ScreenHeight);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_DRAW, ST_SUM, ST_SUMLAST, ST_MUL, ST_OUT
  } state_e;

  state_e state_q;
  logic [AW:0] cnt_q;
  logic [12:0] x0_q, x1_q, y1_q, cx_q, cy_q;
  logic [2:0]  gr_q, gc_q;
  logic        glyph_q;
  logic [12:0] gx_q, gy_q;
  logic [7:0]  code_q, color_q;
  logic [31:0] hash_q, res_q;
  logic        ovalid_q;

  // Input unpack
  logic [2:0] act;
  logic signed [12:0] xi, yi, wi, hi;
  assign act = s_axis_tdata_i[2:0];
  assign xi  = 13'(signed'(s_axis_tdata_i[13:3]));
  assign yi  = 13'(signed'(s_axis_tdata_i[24:14]));
  assign wi  = 13'(signed'(s_axis_tdata_i[35:25]));
  assign hi  = 13'(signed'(s_axis_tdata_i[46:36]));

  localparam logic signed [12:0] SW = 13'(ScreenWidth);
  localparam logic signed [12:0] SH = 13'(ScreenHeight);

  logic signed [12:0] rx0, ry0, rx1, ry1;
  assign rx0 = (xi < 0) ? 13'sd0 : xi;
  assign ry0 = (yi < 0) ? 13'sd0 : yi;
  assign rx1 = (xi + wi > SW) ? SW : xi + wi;
  assign ry1 = (yi + hi > SH) ? SH : yi + hi;

  // RAM port
  logic          we;
  logic [AW-1:0] addr;
  logic [7:0]    wdata, rdata;
  logic signed [12:0] px, py;
  logic          inb, gbit;
  logic [7:0]    grow;

  assign grow = glyph_row(code_q, gr_q);
  assign gbit = grow[3'd7 - gc_q];
  assign px = glyph_q ? signed'(gx_q + 13'(gc_q)) : signed'(cx_q);
  assign py = glyph_q ? signed'(gy_q + 13'(gr_q)) : signed'(cy_q);
  assign inb = (px >= 0) && (px < SW) && (py >= 0) && (py < SH);

  always_comb begin
    we    = 1'b0;
    wdata = color_q;
    addr  = cnt_q[AW-1:0];
    unique case (state_q)
      ST_INIT: begin
        we = 1'b1;
        wdata = 8'd0;
      end
      ST_DRAW: begin
        addr = AW'(py[YW-1:0]) * AW'(ScreenWidth) + AW'(px[XW-1:0]);
        we = inb && (!glyph_q || gbit);
      end
      default: ;
    endcase
  end

  fde_ram #(.Width(8), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE) && !ovalid_q;
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = res_q;

  logic last_cnt;
  assign last_cnt = (cnt_q == (AW+1)'(Depth - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      glyph_q  <= 1'b0;
    end else begin
      if (ovalid_q && m_axis_tready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        ST_INIT: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_cnt) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid_i && s_axis_tready_o) begin
            color_q <= s_axis_tdata_i[62:55];
            code_q  <= s_axis_tdata_i[54:47];
            res_q   <= 32'd0;
            cnt_q   <= '0;
            gr_q <= '0; gc_q <= '0;
            gx_q <= xi; gy_q <= yi;
            glyph_q <= 1'b0;
            unique case (act)
              ACT_CLEAR: begin
                x0_q <= 13'd0; cx_q <= 13'd0; cy_q <= 13'd0;
                x1_q <= SW; y1_q <= SH; state_q <= ST_DRAW;
              end
              ACT_POINT: begin
                x0_q <= xi; cx_q <= xi; cy_q <= yi;
                x1_q <= xi + 13'sd1; y1_q <= yi + 13'sd1; state_q <= ST_DRAW;
              end
              ACT_RECT: begin
                if (wi > 0 && hi > 0 && rx0 < rx1 && ry0 < ry1) begin
                  x0_q <= rx0; cx_q <= rx0; cy_q <= ry0;
                  x1_q <= rx1; y1_q <= ry1; state_q <= ST_DRAW;
                end else begin
                  ovalid_q <= 1'b1;
                end
              end
              ACT_GLYPH: begin
                glyph_q <= 1'b1; state_q <= ST_DRAW;
              end
              ACT_CHKSUM: begin
                hash_q <= FnvBasis; state_q <= ST_SUM;
              end
              default: ovalid_q <= 1'b1;
            endcase
          end
        end
        ST_DRAW: begin
          if (glyph_q) begin
            gc_q <= gc_q + 1'b1;
            if (gc_q == 3'd7) begin
              gr_q <= gr_q + 1'b1;
              if (gr_q == 3'd7) begin
                state_q <= ST_IDLE; ovalid_q <= 1'b1;
              end
            end
          end else if (signed'(cx_q) + 13'sd1 >= signed'(x1_q)) begin
            cx_q <= x0_q;
            cy_q <= cy_q + 1'b1;
            if (signed'(cy_q) + 13'sd1 >= signed'(y1_q)) begin
              state_q <= ST_IDLE; ovalid_q <= 1'b1;
            end
          end else begin
            cx_q <= cx_q + 1'b1;
          end
        end
        // Read address cnt_q issued; data arrives next cycle. Alternate fold and multiply.
        ST_SUM: begin
          state_q <= ST_MUL;
          if (cnt_q != '0) hash_q <= hash_q * FnvPrime;
        end
        ST_MUL: begin
          hash_q <= hash_q ^ {24'd0, rdata};
          cnt_q  <= cnt_q + 1'b1;
          state_q <= last_cnt ? ST_SUMLAST : ST_SUM;
        end
        ST_SUMLAST: begin
          hash_q <= hash_q * FnvPrime;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          res_q <= hash_q; ovalid_q <= 1'b1; state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Never accept a command while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> !s_axis_tready_o) else $error("accept with pending result");
  // Writes only in init or draw
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ST_INIT || state_q == ST_DRAW)) else $error("stray write");
  // Result word holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready_i) |=> $stable(res_q)) else $error("result changed");
endmodule

>>> dv/tb_top.sv
// Testbench for framebuffer_draw_engine: a queue-fed stream driver, a result monitor
// and a pixel-level frame store predictor checked word by word.
// Depends on fde_pkg and the framebuffer_draw_engine RTL.
module tb_top;
  import fde_pkg::*;

  localparam int Width     = 128;
  localparam int Height    = 64;
  localparam int Pixels    = Width * Height;
  localparam int IdleLimit = 100000;

  typedef struct {
    logic [2:0]  act;
    logic [10:0] x;
    logic [10:0] y;
    logic [10:0] w;
    logic [10:0] h;
    logic [7:0]  code;
    logic [7:0]  color;
    bit          drain;   // hold this word until every result is back
  } draw_cmd_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;

  draw_cmd_t   cmd_q[$];
  logic [31:0] result_q[$];
  logic [7:0]  pixel_mem[Pixels];
  draw_cmd_t   cur_cmd;
  int          gap_left;
  int          stall_left;
  int          holdoff_left;
  int          sent_cnt;
  int          result_cnt;
  int          idle_cnt;
  int          err_cnt;

  framebuffer_draw_engine dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // 8x8 font, row 0 in the top byte.
  function automatic logic [63:0] font_bits(input logic [7:0] code);
    case (code)
      "A":     return 64'h18244242_7E424200;
      "H":     return 64'h4242427E_42424200;
      "I":     return 64'h3E080808_08083E00;
      "O":     return 64'h3C424242_42423C00;
      "X":     return 64'h42241818_18244200;
      default: return 64'h0;
    endcase
  endfunction

  function automatic void plot(input int px, input int py, input logic [7:0] color);
    if (px >= 0 && px < Width && py >= 0 && py < Height) pixel_mem[py * Width + px] = color;
  endfunction

  // Applies one command to the frame store copy; returns the expected result word.
  function automatic logic [31:0] draw_predict(input draw_cmd_t c);
    int          x;
    int          y;
    int          w;
    int          h;
    logic [63:0] bits;
    logic [31:0] fnv;
    x   = $signed(c.x);
    y   = $signed(c.y);
    w   = $signed(c.w);
    h   = $signed(c.h);
    fnv = 32'h0;
    case (c.act)
      ACT_CLEAR: begin
        for (int i = 0; i < Pixels; i++) pixel_mem[i] = c.color;
      end
      ACT_POINT: plot(x, y, c.color);
      ACT_RECT: begin
        if (w > 0 && h > 0) begin
          for (int r = y; r < y + h; r++)
            for (int k = x; k < x + w; k++) plot(k, r, c.color);
        end
      end
      ACT_GLYPH: begin
        bits = font_bits(c.code);
        for (int r = 0; r < 8; r++)
          for (int k = 0; k < 8; k++)
            if (bits[63 - 8 * r - k]) plot(x + k, y + r, c.color);
      end
      ACT_CHKSUM: begin
        fnv = FnvBasis;
        for (int i = 0; i < Pixels; i++) fnv = (fnv ^ {24'h0, pixel_mem[i]}) * FnvPrime;
      end
      default: ;
    endcase
    return fnv;
  endfunction

  function automatic void add_cmd(input int act, input int x, input int y,
                                  input int w, input int h, input int code,
                                  input int color);
    draw_cmd_t c;
    c.act   = act[2:0];
    c.x     = x[10:0];
    c.y     = y[10:0];
    c.w     = w[10:0];
    c.h     = h[10:0];
    c.code  = code[7:0];
    c.color = color[7:0];
    c.drain = 1'b0;
    cmd_q.push_back(c);
  endfunction

  function automatic int coord();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2047) - 1024;
    return $urandom_range(0, 150) - 12;
  endfunction

  // Driver: presents queued words, predicts each one at its handshake.
  always @(posedge clk_i or negedge rst_ni) begin
    logic fire;
    logic nv;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      gap_left = 0;
      sent_cnt = 0;
    end else begin
      fire = s_axis_tvalid_i && s_axis_tready_o;
      nv   = s_axis_tvalid_i && !fire;
      if (fire) begin
        result_q.push_back(draw_predict(cur_cmd));
        sent_cnt++;
      end
      if (!s_axis_tvalid_i || fire) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() > 0 &&
                     !(cmd_q[0].drain && (result_q.size() > 0 || fire))) begin
          cur_cmd = cmd_q.pop_front();
          s_axis_tdata_i <= {1'b0, cur_cmd.color, cur_cmd.code, cur_cmd.h, cur_cmd.w,
                             cur_cmd.y, cur_cmd.x, cur_cmd.act};
          nv = 1'b1;
          // no-gap stretch in the middle of the random part
          gap_left = (sent_cnt >= 45 && sent_cnt < 60) ? 0 : $urandom_range(0, 15);
        end
      end
      s_axis_tvalid_i <= nv;
    end
  end

  // Monitor: random backpressure, one long hold-off, in-order compare.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left   = 0;
      holdoff_left = 0;
      result_cnt   = 0;
      err_cnt      = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: result word with nothing expected, actual %h", $time, m_axis_tdata_o);
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata_o !== want) begin
            $display("%0t: result_value mismatch, expected %h actual %h", $time, want,
                     m_axis_tdata_o);
            err_cnt++;
          end
        end
        result_cnt++;
        stall_left = (result_cnt >= 70 && result_cnt < 85) ? 0 : $urandom_range(0, 15);
        if (result_cnt == 30) holdoff_left = 400;   // lets the engine back up
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    int pick;
    cur_cmd  = '{default: '0};
    for (int i = 0; i < Pixels; i++) pixel_mem[i] = 8'h00;

    // directed: checksum of the reset store, clipping edges, empty rects, font, unknown actions
    add_cmd(ACT_CHKSUM, 0, 0, 0, 0, 8'h00, 8'h00);
    add_cmd(ACT_CLEAR, 0, 0, 0, 0, 8'h00, 8'hA5);
    add_cmd(ACT_POINT, 0, 0, 0, 0, 8'h00, 8'hFF);
    add_cmd(ACT_POINT, Width - 1, Height - 1, 0, 0, 8'hFF, 8'h00);
    add_cmd(ACT_POINT, -1, 5, 0, 0, 8'h00, 8'h11);
    add_cmd(ACT_POINT, Width, 0, 0, 0, 8'h00, 8'h22);
    add_cmd(ACT_POINT, -1024, 1023, -1024, 1023, 8'h00, 8'h33);
    add_cmd(ACT_RECT, -5, -5, 20, 20, 8'h00, 8'h44);
    add_cmd(ACT_RECT, 10, 10, 0, 5, 8'h00, 8'h55);
    add_cmd(ACT_RECT, 10, 10, 5, -1, 8'h00, 8'h66);
    add_cmd(ACT_RECT, -1024, -1024, 1023, 1023, 8'h00, 8'h77);
    add_cmd(ACT_RECT, 120, 60, 1023, 1023, 8'h00, 8'h88);
    add_cmd(ACT_GLYPH, 20, 20, 0, 0, "A", 8'h01);
    add_cmd(ACT_GLYPH, 30, 20, 0, 0, "H", 8'h02);
    add_cmd(ACT_GLYPH, 40, 20, 0, 0, "I", 8'h03);
    add_cmd(ACT_GLYPH, 50, 20, 0, 0, "O", 8'h04);
    add_cmd(ACT_GLYPH, 60, 20, 0, 0, "X", 8'h05);
    add_cmd(ACT_GLYPH, 70, 20, 0, 0, " ", 8'hFF);
    add_cmd(ACT_GLYPH, 80, 20, 0, 0, 8'hFF, 8'hFF);   // unknown code draws nothing
    add_cmd(ACT_GLYPH, Width - 4, Height - 3, 0, 0, "X", 8'h99);
    add_cmd(ACT_GLYPH, -3, -3, 0, 0, "O", 8'hCC);
    add_cmd(3'd5, 1, 1, 1, 1, "A", 8'hEE);
    add_cmd(3'd6, 0, 0, 0, 0, 8'h00, 8'h00);
    add_cmd(3'd7, 1023, 1023, 1023, 1023, 8'hFF, 8'hFF);
    add_cmd(ACT_CHKSUM, 0, 0, 0, 0, 8'h00, 8'h00);

    for (int n = 0; n < 75; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        add_cmd(ACT_CLEAR, coord(), coord(), 0, 0, $urandom_range(0, 255),
                $urandom_range(0, 255));
      end else if (pick < 14) begin
        add_cmd(ACT_CHKSUM, coord(), coord(), coord(), coord(), $urandom_range(0, 255),
                $urandom_range(0, 255));
      end else if (pick < 34) begin
        add_cmd(ACT_POINT, coord(), coord(), coord(), coord(), $urandom_range(0, 255),
                $urandom_range(0, 255));
      end else if (pick < 62) begin
        // mostly small boxes; now and then any width and height at all
        if ($urandom_range(0, 7) == 0)
          add_cmd(ACT_RECT, coord(), coord(), $urandom_range(0, 2047) - 1024,
                  $urandom_range(0, 2047) - 1024, $urandom_range(0, 255),
                  $urandom_range(0, 255));
        else
          add_cmd(ACT_RECT, coord(), coord(), $urandom_range(0, 44) - 4,
                  $urandom_range(0, 24) - 4, $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (pick < 95) begin
        case ($urandom_range(0, 6))
          0: add_cmd(ACT_GLYPH, coord(), coord(), 0, 0, "A", $urandom_range(0, 255));
          1: add_cmd(ACT_GLYPH, coord(), coord(), 0, 0, "H", $urandom_range(0, 255));
          2: add_cmd(ACT_GLYPH, coord(), coord(), 0, 0, "I", $urandom_range(0, 255));
          3: add_cmd(ACT_GLYPH, coord(), coord(), 0, 0, "O", $urandom_range(0, 255));
          4: add_cmd(ACT_GLYPH, coord(), coord(), 0, 0, "X", $urandom_range(0, 255));
          default: add_cmd(ACT_GLYPH, coord(), coord(), coord(), coord(),
                           $urandom_range(0, 255), $urandom_range(0, 255));
        endcase
      end else begin
        add_cmd($urandom_range(5, 7), coord(), coord(), coord(), coord(),
                $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
    add_cmd(ACT_CHKSUM, 0, 0, 0, 0, 8'h00, 8'h00);
    cmd_q[70].drain = 1'b1;   // sender waits for the pipe to empty here

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (cmd_q.size() > 0 || s_axis_tvalid_i || result_q.size() > 0);
    repeat (50) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

>>> framebuffer_draw_engine.f
sv/fde_pkg.sv
sv/fde_ram.sv
sv/framebuffer_draw_engine.sv
dv/tb_top.sv
